FILE: src/jse_pkg.sv
// Shared types, character constants and helper functions of the JSON string escaper.
// Used by the front decoder, the command queue, the back expander and the top level.
`default_nettype none

package jse_pkg;

	// Default depth of the queue between the decoder and the expander.
	localparam int JSE_CMD_DEPTH = 4;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CTL_BS    = 8'h08;
	localparam logic [7:0] CTL_TAB   = 8'h09;
	localparam logic [7:0] CTL_LF    = 8'h0A;
	localparam logic [7:0] CTL_FF    = 8'h0C;
	localparam logic [7:0] CTL_CR    = 8'h0D;
	localparam logic [7:0] CTL_MAX   = 8'h1F;
	localparam logic [15:0] REPL_CP  = 16'hFFFD;

	// What the main part of one request expands to.
	typedef enum logic [2:0] {
		K_NONE,    // nothing beyond the replacements
		K_RAW1,    // one byte copied as it is
		K_ESC2,    // backslash and one letter
		K_U16,     // one \uXXXX escape
		K_PAIR,    // two \uXXXX escapes, high surrogate first
		K_RAWSEQ   // a valid UTF-8 sequence copied raw
	} kind_t;

	// One request from the decoder to the expander.
	typedef struct packed {
		logic        esc;       // escaping of non-ASCII in force
		logic [2:0]  repl_cnt;  // replacement characters before the main part
		kind_t       kind;
		logic [3:0]  main_len;  // characters in the main part
		logic [31:0] data;      // bytes or code units of the main part
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'h0, nib};
		end else begin
			c = 8'h37 + {4'h0, nib};
		end
		return c;
	endfunction

	// Character idx of the six-character escape \uXXXX of value v.
	function automatic logic [7:0] u16_char(input logic [15:0] v, input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = CH_BSLASH;
			3'd1: c = CH_U;
			3'd2: c = hex_char(v[15:12]);
			3'd3: c = hex_char(v[11:8]);
			3'd4: c = hex_char(v[7:4]);
			3'd5: c = hex_char(v[3:0]);
			default: c = CH_BSLASH;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/jse_front.sv
// UTF-8 decoder: accepts one byte per cycle while accept is high, keeps
// partial sequences, makes at most one request per byte. Uses jse_pkg.
`default_nettype none

module jse_front
	import jse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_string,
	input  wire logic       esc,
	output cmd_t            cmd,
	output logic            cmd_valid
);

	logic [1:0] held_cnt_q;
	logic [7:0] held_q [3];

	logic [1:0]  nxt_cnt;
	logic        wr_held;
	logic [1:0]  wr_idx;
	logic        cont_ok;
	logic [2:0]  seq_len;
	logic [20:0] cp;
	logic [19:0] n;
	logic [7:0]  lead;

	assign lead = held_q[0];

	always_comb begin
		cont_ok = (in_byte[7:6] == 2'b10);
		if (held_cnt_q == 2'd1) begin
			if (lead == 8'hE0 && in_byte < 8'hA0) cont_ok = 1'b0;
			if (lead == 8'hED && in_byte > 8'h9F) cont_ok = 1'b0;
			if (lead == 8'hF0 && in_byte < 8'h90) cont_ok = 1'b0;
			if (lead == 8'hF4 && in_byte > 8'h8F) cont_ok = 1'b0;
		end
		if (lead >= 8'hF0) begin
			seq_len = 3'd4;
		end else if (lead >= 8'hE0) begin
			seq_len = 3'd3;
		end else begin
			seq_len = 3'd2;
		end
		case (held_cnt_q)
			2'd1: cp = {10'h0, held_q[0][4:0], in_byte[5:0]};
			2'd2: cp = {5'h0, held_q[0][3:0], held_q[1][5:0], in_byte[5:0]};
			2'd3: cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], in_byte[5:0]};
			default: cp = 21'h0;
		endcase
		n = 20'(cp - 21'h10000);
	end

	always_comb begin
		cmd.esc      = esc;
		cmd.repl_cnt = 3'd0;
		cmd.kind     = K_NONE;
		cmd.main_len = 4'd0;
		cmd.data     = 32'h0;
		nxt_cnt      = held_cnt_q;
		wr_held      = 1'b0;
		wr_idx       = 2'd0;
		if (held_cnt_q != 2'd0 && cont_ok) begin
			if ({1'b0, held_cnt_q} + 3'd1 == seq_len) begin
				nxt_cnt = 2'd0;
				if (!esc) begin
					cmd.kind     = K_RAWSEQ;
					cmd.main_len = {2'b00, held_cnt_q} + 4'd1;
					case (held_cnt_q)
						2'd1: cmd.data = {16'h0, in_byte, held_q[0]};
						2'd2: cmd.data = {8'h0, in_byte, held_q[1], held_q[0]};
						default: cmd.data = {in_byte, held_q[2], held_q[1], held_q[0]};
					endcase
				end else if (cp[20:16] == 5'd0) begin
					cmd.kind     = K_U16;
					cmd.main_len = 4'd6;
					cmd.data     = {16'h0, cp[15:0]};
				end else begin
					cmd.kind     = K_PAIR;
					cmd.main_len = 4'd12;
					cmd.data     = {6'b110110, n[19:10], 6'b110111, n[9:0]};
				end
			end else begin
				wr_held = 1'b1;
				wr_idx  = held_cnt_q;
				nxt_cnt = held_cnt_q + 2'd1;
			end
		end else begin
			// Every byte already held becomes one replacement of its own.
			cmd.repl_cnt = {1'b0, held_cnt_q};
			nxt_cnt      = 2'd0;
			if (!in_byte[7]) begin
				case (in_byte)
					CH_QUOTE, CH_BSLASH: begin
						cmd.kind = K_ESC2;
						cmd.data = {24'h0, in_byte};
					end
					CTL_BS: begin
						cmd.kind = K_ESC2;
						cmd.data = {24'h0, CH_B};
					end
					CTL_FF: begin
						cmd.kind = K_ESC2;
						cmd.data = {24'h0, CH_F};
					end
					CTL_LF: begin
						cmd.kind = K_ESC2;
						cmd.data = {24'h0, CH_N};
					end
					CTL_CR: begin
						cmd.kind = K_ESC2;
						cmd.data = {24'h0, CH_R};
					end
					CTL_TAB: begin
						cmd.kind = K_ESC2;
						cmd.data = {24'h0, CH_T};
					end
					default: begin
						cmd.data = {24'h0, in_byte};
						cmd.kind = (in_byte <= CTL_MAX) ? K_U16 : K_RAW1;
					end
				endcase
				case (cmd.kind)
					K_ESC2:  cmd.main_len = 4'd2;
					K_U16:   cmd.main_len = 4'd6;
					default: cmd.main_len = 4'd1;
				endcase
			end else if (in_byte >= 8'hC2 && in_byte <= 8'hF4) begin
				wr_held = 1'b1;
				wr_idx  = 2'd0;
				nxt_cnt = 2'd1;
			end else begin
				cmd.repl_cnt = {1'b0, held_cnt_q} + 3'd1;
			end
		end
		if (end_of_string) begin
			cmd.repl_cnt = cmd.repl_cnt + {1'b0, nxt_cnt};
			nxt_cnt      = 2'd0;
		end
		cmd_valid = (cmd.repl_cnt != 3'd0) || (cmd.kind != K_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= nxt_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_held) begin
			held_q[wr_idx] <= in_byte;
		end
	end

	a_eos_flush: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_string |=> held_cnt_q == 2'd0)
		else $error("sequence still pending after end of string");

	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(held_cnt_q))
		else $error("held count changed without an accepted byte");

endmodule

`default_nettype wire

FILE: src/jse_cmdq.sv
// Short request queue between the decoder and the expander.
// Depends on jse_pkg for the request type.
`default_nettype none

module jse_cmdq
	import jse_pkg::*;
#(
	parameter int DEPTH = JSE_CMD_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_cmd,
	input  wire logic rd_en,
	output cmd_t      head,
	output logic      full,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en |-> !full) and (rd_en |-> !empty))
		else $error("request queue written while full or read while empty");

endmodule

`default_nettype wire

FILE: src/jse_back.sv
// Expander: walks the request at the head of the queue one output character per cycle
// while take is high. Depends on jse_pkg.
`default_nettype none

module jse_back
	import jse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       head,
	input  wire logic       head_valid,
	input  wire logic       take,
	output logic            done,
	output logic [7:0]      out_char,
	output logic            invalid_seen,
	output logic            last_of_run
);

	logic [2:0] rep_q;
	logic [3:0] sub_q;
	logic       in_repl;
	logic [3:0] repl_len;
	logic       unit_end;

	assign in_repl  = (rep_q < head.repl_cnt);
	assign repl_len = head.esc ? 4'd6 : 4'd3;
	assign unit_end = in_repl && (sub_q == repl_len - 4'd1);

	always_comb begin
		out_char     = 8'h00;
		invalid_seen = in_repl;
		if (in_repl) begin
			if (head.esc) begin
				out_char = u16_char(REPL_CP, sub_q[2:0]);
			end else begin
				case (sub_q[1:0])
					2'd0: out_char = 8'hEF;
					2'd1: out_char = 8'hBF;
					default: out_char = 8'hBD;
				endcase
			end
		end else begin
			case (head.kind)
				K_RAW1: out_char = head.data[7:0];
				K_ESC2: out_char = (sub_q == 4'd0) ? CH_BSLASH : head.data[7:0];
				K_U16:  out_char = u16_char(head.data[15:0], sub_q[2:0]);
				K_PAIR: begin
					if (sub_q < 4'd6) begin
						out_char = u16_char(head.data[31:16], sub_q[2:0]);
					end else begin
						out_char = u16_char(head.data[15:0], 3'(sub_q - 4'd6));
					end
				end
				K_RAWSEQ: begin
					case (sub_q[1:0])
						2'd0: out_char = head.data[7:0];
						2'd1: out_char = head.data[15:8];
						2'd2: out_char = head.data[23:16];
						default: out_char = head.data[31:24];
					endcase
				end
				default: out_char = 8'h00;
			endcase
		end
		if (head.main_len == 4'd0) begin
			last_of_run = unit_end && (rep_q == head.repl_cnt - 3'd1);
		end else begin
			last_of_run = !in_repl && (sub_q == head.main_len - 4'd1);
		end
	end

	assign done = take && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= 3'd0;
			sub_q <= 4'd0;
		end else if (take) begin
			if (last_of_run) begin
				rep_q <= 3'd0;
				sub_q <= 4'd0;
			end else if (unit_end) begin
				rep_q <= rep_q + 3'd1;
				sub_q <= 4'd0;
			end else begin
				sub_q <= sub_q + 4'd1;
			end
		end
	end

	a_nonempty_req: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head.repl_cnt != 3'd0 || head.main_len != 4'd0))
		else $error("request without any output characters reached the expander");

	a_done_resets: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> rep_q == 3'd0 && sub_q == 4'd0)
		else $error("expander counters not cleared after finishing a request");

endmodule

`default_nettype wire

FILE: src/json_string_escaper_utf8.sv
// Top level of the JSON string escaper with UTF-8 validation.
// Instantiates jse_front, jse_cmdq and jse_back; depends on jse_pkg.
//
// Usage: string bytes enter on the push/full queue port, one byte per request,
// with end_of_string on the final byte. An input request is taken at a clock edge
// where push is high and full is low. Escaped JSON characters leave on the
// empty/pop port: while empty is low the oldest character is on out_char, with
// invalid_seen and last_of_run, and it is taken at an edge where pop is high.
// The decoder accepts one byte per cycle while full is low and turns it into at
// most one expansion request for a queue of CMD_DEPTH entries; the expander emits
// one character per cycle while pop is high. A byte's request passes the queue
// before its characters show. Plain ASCII therefore sustains one byte per cycle;
// a byte that expands to k characters holds the expander for all k of them (two
// for short escapes, six for \uXXXX, up to 24 when replacements pile up), and the
// decoder runs ahead until the queue fills, at which point full rises. A stalled
// receiver simply holds the current character; nothing is lost. Reset clears the
// pending sequence and the queue and sets escape_non_ascii to 1; cfg_we writes it
// from cfg_wdata and should only be used while no request is in flight.
`default_nettype none

module json_string_escaper_utf8
	import jse_pkg::*;
#(
	parameter int CMD_DEPTH = JSE_CMD_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_string,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_char,
	output logic            invalid_seen,
	output logic            last_of_run,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata
);

	logic esc_q;
	logic accept;
	cmd_t front_cmd;
	logic front_valid;
	cmd_t head;
	logic take;
	logic done;

	// Escape-non-ASCII control register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b1;
		end else if (cfg_we) begin
			esc_q <= cfg_wdata;
		end
	end

	assign accept = push && !full;
	assign take   = pop && !empty;

	// The decoder classifies each byte and keeps any partial UTF-8 sequence.
	jse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.esc           (esc_q),
		.cmd           (front_cmd),
		.cmd_valid     (front_valid)
	);

	// Bytes that only extend a held sequence produce no request.
	jse_cmdq #(
		.DEPTH (CMD_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && front_valid),
		.wr_cmd (front_cmd),
		.rd_en  (done),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	jse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (!empty),
		.take         (take),
		.done         (done),
		.out_char     (out_char),
		.invalid_seen (invalid_seen),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire
